// ===== hw/rtl/dlcg_pkg.sv =====
// Shared types and constants for the distance link contact generator.
// No dependencies; every other file of the block imports this package.
package dlcg_pkg;

    localparam int CW    = 32;             // coordinate width
    localparam int NFB   = 14;             // fraction bits of a normal component
    localparam int SW    = CW + 1;         // width of a difference magnitude and of the root
    localparam int SUMW  = 2 * SW + 2;     // sum of three squares
    localparam int QW    = NFB + 2;        // quotient bits (one guard bit for rounding)
    localparam int NUMW  = SW + NFB + 1;   // divider numerator width
    localparam int NW    = 16;             // normal component field width
    localparam int TAGW  = 16;
    localparam int RESTW = 31;
    localparam int BW    = 17;

    localparam logic [RESTW-1:0] PEN_MAX = '1;

    localparam logic KIND_CABLE = 1'b0;
    localparam logic KIND_ROD   = 1'b1;

    typedef logic [2:0][SW-1:0] mag3_t;
    typedef logic [2:0][QW-1:0] quot3_t;

    typedef struct packed {
        logic [TAGW-1:0]        link_tag;
        logic                   link_kind;
        logic                   anchored;
        logic signed [CW-1:0]   first_x;
        logic signed [CW-1:0]   first_y;
        logic signed [CW-1:0]   first_z;
        logic signed [CW-1:0]   second_x;
        logic signed [CW-1:0]   second_y;
        logic signed [CW-1:0]   second_z;
        logic [RESTW-1:0]       rest_length;
        logic [BW-1:0]          bounce_factor;
    } link_req_t;

    typedef struct packed {
        logic [TAGW-1:0]        contact_tag;
        logic                   contact_anchored;
        logic signed [NW-1:0]   normal_x;
        logic signed [NW-1:0]   normal_y;
        logic signed [NW-1:0]   normal_z;
        logic [RESTW-1:0]       penetration;
        logic [BW-1:0]          contact_bounce;
    } contact_t;

    // Sideband that rides along the square root pipeline.
    typedef struct packed {
        logic [TAGW-1:0]  tag;
        logic             kind;
        logic             anchored;
        mag3_t            mag;
        logic [2:0]       neg;
        logic [RESTW-1:0] rest;
        logic [BW-1:0]    bounce;
    } sq_side_t;

    // Sideband that rides along the divider pipeline.
    typedef struct packed {
        logic [TAGW-1:0]  tag;
        logic             anchored;
        logic [2:0]       neg;
        logic             dzero;
        logic [RESTW-1:0] pen;
        logic [BW-1:0]    bounce;
    } dv_side_t;

endpackage

// ===== hw/rtl/dlcg_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on dlcg_pkg.
module dlcg_sqrt_pipe (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [dlcg_pkg::SUMW-1:0] in_sum,
    input  dlcg_pkg::sq_side_t      in_side,
    output logic                    out_valid,
    output logic [dlcg_pkg::SW-1:0] out_root,
    output dlcg_pkg::sq_side_t      out_side
);
    import dlcg_pkg::*;

    logic            vld_reg  [1:SW];
    logic [SUMW-1:0] rem_reg  [1:SW];
    logic [SW-1:0]   root_reg [1:SW];
    sq_side_t        side_reg [1:SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        localparam int B = SW - 1 - k;
        logic            v_in;
        logic [SUMW-1:0] rem_in;
        logic [SW-1:0]   root_in;
        sq_side_t        side_in;
        logic [SUMW-1:0] trial;
        logic            take;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_sum;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = vld_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign side_in = side_reg[k];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b); r has no bits below b+1 yet.
        assign trial = (SUMW'(root_in) << (B + 1)) | (SUMW'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= take ? rem_in - trial : rem_in;
                root_reg[k+1] <= take ? (root_in | (SW'(1) << B)) : root_in;
                side_reg[k+1] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[SW];
    assign out_root  = root_reg[SW];
    assign out_side  = side_reg[SW];

endmodule

// ===== hw/rtl/dlcg_div_pipe.sv =====
// Three parallel pipelined restoring dividers, one quotient bit per stage.
// Depends on dlcg_pkg.
module dlcg_div_pipe (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  dlcg_pkg::mag3_t         in_mag,
    input  logic [dlcg_pkg::SW-1:0] in_dist,
    input  dlcg_pkg::dv_side_t      in_side,
    output logic                    out_valid,
    output dlcg_pkg::quot3_t        out_quot,
    output dlcg_pkg::dv_side_t      out_side
);
    import dlcg_pkg::*;

    logic                  vld_reg  [1:QW];
    logic [2:0][NUMW-1:0]  rem_reg  [1:QW];
    quot3_t                quot_reg [1:QW];
    logic [SW-1:0]         dist_reg [1:QW];
    dv_side_t              side_reg [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int I = QW - 1 - k;
        logic                 v_in;
        logic [2:0][NUMW-1:0] rem_in;
        quot3_t               quot_in;
        logic [SW-1:0]        dist_in;
        dv_side_t             side_in;
        logic [NUMW-1:0]      trial;
        logic [2:0][NUMW-1:0] rem_nx;
        quot3_t               quot_nx;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign quot_in = '0;
            assign dist_in = in_dist;
            assign side_in = in_side;
            for (genvar a = 0; a < 3; a++) begin : g_num
                assign rem_in[a] = NUMW'(in_mag[a]) << (NFB + 1);
            end
        end else begin : g_next
            assign v_in    = vld_reg[k];
            assign rem_in  = rem_reg[k];
            assign quot_in = quot_reg[k];
            assign dist_in = dist_reg[k];
            assign side_in = side_reg[k];
        end

        assign trial = NUMW'(dist_in) << I;

        always_comb begin
            for (int a = 0; a < 3; a++) begin
                if (rem_in[a] >= trial) begin
                    rem_nx[a]  = rem_in[a] - trial;
                    quot_nx[a] = quot_in[a] | (QW'(1) << I);
                end else begin
                    rem_nx[a]  = rem_in[a];
                    quot_nx[a] = quot_in[a];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_nx;
                quot_reg[k+1] <= quot_nx;
                dist_reg[k+1] <= dist_in;
                side_reg[k+1] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quot  = quot_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

// ===== hw/rtl/distance_link_contact_generator_unit.sv =====
// Top level of the distance link contact generator.
// Depends on dlcg_pkg, dlcg_sqrt_pipe and dlcg_div_pipe.

// The unit takes one link request per clock cycle while s_ready is high and
// delivers at most one contact for it, in request order. The pipeline holds
// the two bit-serial pipelines: 33 stages of square root (one root bit
// each) and 16 stages of normal division (one quotient bit each), plus the
// difference, square, sum, decision and output registers. Requests that produce
// no contact (a slack cable, a rod at exactly its length) simply vanish from the
// pipeline and leave a bubble. The whole pipeline advances together whenever the
// output register is empty or being read, so s_ready is that same condition and
// a stall loses or repeats nothing. Coincident points give a zero normal, and a
// penetration beyond its largest value saturates there.
module distance_link_contact_generator_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dlcg_pkg::link_req_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dlcg_pkg::contact_t    m_data
);
    import dlcg_pkg::*;

    logic en;

    // Stage 1: coordinate differences and their magnitudes.
    logic                  v1_reg;
    sq_side_t              side1_reg;
    logic signed [SW-1:0]  diff [3];
    logic signed [CW-1:0]  pa [3];
    logic signed [CW-1:0]  pb [3];
    mag3_t                 mag_next;
    logic [2:0]            neg_next;

    // Stage 2: squares. Stage 3: sum.
    logic                  v2_reg;
    sq_side_t              side2_reg;
    logic [2*SW-1:0]       sq_reg [3];
    logic                  v3_reg;
    sq_side_t              side3_reg;
    logic [SUMW-1:0]       sum_reg;

    // Square root output.
    logic                  sq_valid;
    logic [SW-1:0]         sq_root;
    sq_side_t              sq_side;

    // Stage after the root: contact decision.
    logic                  v4_reg;
    logic                  keep_next;
    dv_side_t              dv_next;
    dv_side_t              dv_reg;
    mag3_t                 dmag_reg;
    logic [SW-1:0]         dist_reg;
    logic [SW-1:0]         rest_ext;
    logic [SW-1:0]         err;
    logic                  is_short;

    // Divider output and result register.
    logic                  dv_valid;
    quot3_t                dv_quot;
    dv_side_t              dv_side;
    logic [QW-1:0]         rounded [3];
    logic [NW-1:0]         nrm [3];
    logic                  m_valid_reg;
    contact_t              m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign pa[0] = s_data.first_x;
    assign pa[1] = s_data.first_y;
    assign pa[2] = s_data.first_z;
    assign pb[0] = s_data.second_x;
    assign pb[1] = s_data.second_y;
    assign pb[2] = s_data.second_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a]     = SW'(pb[a]) - SW'(pa[a]);
            neg_next[a] = diff[a][SW-1];
            mag_next[a] = neg_next[a] ? SW'(-diff[a]) : SW'(diff[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg.tag      <= s_data.link_tag;
            side1_reg.kind     <= s_data.link_kind;
            side1_reg.anchored <= s_data.anchored;
            side1_reg.mag      <= mag_next;
            side1_reg.neg      <= neg_next;
            side1_reg.rest     <= s_data.rest_length;
            side1_reg.bounce   <= s_data.bounce_factor;

            side2_reg <= side1_reg;
            for (int a = 0; a < 3; a++) begin
                sq_reg[a] <= (2*SW)'(side1_reg.mag[a]) * (2*SW)'(side1_reg.mag[a]);
            end

            side3_reg <= side2_reg;
            sum_reg   <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        end
    end

    dlcg_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_sum    (sum_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // A rod at its length or a cable shorter than its maximum gives no contact. A
    // compressed rod points the normal back toward the first point.
    always_comb begin
        rest_ext = SW'(sq_side.rest);
        is_short = sq_root < rest_ext;
        err      = is_short ? rest_ext - sq_root : sq_root - rest_ext;
        if (sq_side.kind == KIND_ROD) begin
            keep_next = sq_root != rest_ext;
        end else begin
            keep_next = !is_short;
        end
        dv_next.tag      = sq_side.tag;
        dv_next.anchored = sq_side.anchored;
        for (int a = 0; a < 3; a++) begin
            dv_next.neg[a] = sq_side.neg[a] ^ ((sq_side.kind == KIND_ROD) && is_short);
        end
        dv_next.dzero  = sq_root == '0;
        dv_next.pen    = (err > SW'(PEN_MAX)) ? PEN_MAX : err[RESTW-1:0];
        dv_next.bounce = (sq_side.kind == KIND_ROD) ? '0 : sq_side.bounce;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_valid && keep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg   <= dv_next;
            dmag_reg <= sq_side.mag;
            dist_reg <= sq_root;
        end
    end

    dlcg_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_mag    (dmag_reg),
        .in_dist   (dist_reg),
        .in_side   (dv_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // Round half up from the guard bit, then apply the sign.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rounded[a] = QW'((dv_quot[a] + QW'(1)) >> 1);
            if (dv_side.dzero) begin
                nrm[a] = '0;
            end else if (dv_side.neg[a]) begin
                nrm[a] = NW'(-NW'(rounded[a]));
            end else begin
                nrm[a] = NW'(rounded[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.contact_tag      <= dv_side.tag;
            m_data_reg.contact_anchored <= dv_side.anchored;
            m_data_reg.normal_x         <= nrm[0];
            m_data_reg.normal_y         <= nrm[1];
            m_data_reg.normal_z         <= nrm[2];
            m_data_reg.penetration      <= dv_side.pen;
            m_data_reg.contact_bounce   <= dv_side.bounce;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/dlcg_checker.sv =====
// Port-level checks for the distance link contact generator, bound to the top level.
// Depends on dlcg_pkg and distance_link_contact_generator_unit.
module dlcg_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input dlcg_pkg::link_req_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input dlcg_pkg::contact_t   m_data
);
    import dlcg_pkg::*;

    localparam logic signed [NW-1:0] UNIT_POS = NW'(1 << NFB);
    localparam logic signed [NW-1:0] UNIT_NEG = NW'(-(1 << NFB));

    // A held result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The pipeline only stalls when the output register is held.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input stalled without a held result");

    // Every normal component is a unit-vector component.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.normal_x <= UNIT_POS) && (m_data.normal_x >= UNIT_NEG)
                 && (m_data.normal_y <= UNIT_POS) && (m_data.normal_y >= UNIT_NEG)
                 && (m_data.normal_z <= UNIT_POS) && (m_data.normal_z >= UNIT_NEG))
        else $error("normal component out of range");

endmodule

bind distance_link_contact_generator_unit dlcg_checker u_dlcg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
